// ----- hw/rtl/bsr_pkg.sv -----
// Shared command, status and transaction types for the bounded stack with rotate.
package bsr_pkg;

   // Command codes carried in the request tuser field.
   localparam logic [2:0] CMD_PUSH = 3'd0;
   localparam logic [2:0] CMD_POP  = 3'd1;
   localparam logic [2:0] CMD_PEEK = 3'd2;
   localparam logic [2:0] CMD_DUP  = 3'd3;
   localparam logic [2:0] CMD_ROTR = 3'd4;
   localparam logic [2:0] CMD_ROTL = 3'd5;
   localparam logic [2:0] CMD_SWAP = 3'd6;

   // Status codes returned with every response.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_BADN     = 2'd3;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] value;
      logic [4:0]  count;
   } req_type;

   typedef struct packed {
      logic [31:0] data;
      logic [1:0]  status;
      logic [4:0]  fill;
   } rsp_type;

endpackage

// ----- hw/rtl/bsr_ram.sv -----
// Generic single write port, single read port RAM with a registered read.
module bsr_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/bsr_seq.sv -----
// Command sequencer: fill count, memory read-modify-write and the rotate loop.
module bsr_seq #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [4:0]       max_depth,
   input  logic             start,
   input  bsr_pkg::req_type req,
   output logic             idle,
   input  logic             rsp_free,
   output logic             rsp_load,
   output bsr_pkg::rsp_type rsp,
   output logic             ram_wr_en,
   output logic [AW-1:0]    ram_wr_addr,
   output logic [WIDTH-1:0] ram_wr_data,
   output logic             ram_rd_en,
   output logic [AW-1:0]    ram_rd_addr,
   input  logic [WIDTH-1:0] ram_rd_data
);

   localparam int UW = $clog2(DEPTH + 1);
   localparam int LW = (UW > 5) ? UW : 5;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;
   localparam logic [2:0] S_ROT    = 3'd2;
   localparam logic [2:0] S_ROTEND = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [UW-1:0]    used_ff, used_in;
   logic [31:0]      data_ff, data_in;
   logic [1:0]       status_ff, status_in;
   logic             dup_ff, dup_in;
   logic             right_ff, right_in;
   logic             first_ff, first_in;
   logic [AW-1:0]    cur_ff, cur_in;
   logic [AW-1:0]    left_ff, left_in;
   logic [WIDTH-1:0] keep_ff, keep_in;

   logic [LW-1:0] used_lw, lim, nreq;
   logic [4:0]    n5;
   logic          full, empty, bad_n;
   logic [AW-1:0] top_a, low_a, prev_a, next_a;

   always_comb begin
      n5      = (req.cmd == bsr_pkg::CMD_SWAP) ? 5'd2 : req.count;
      nreq    = LW'(n5);
      used_lw = LW'(used_ff);
      lim     = (LW'(max_depth) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(max_depth);
      full    = used_lw >= lim;
      empty   = (used_ff == '0);
      bad_n   = (n5 == 5'd0) || (nreq > used_lw);
      top_a   = AW'(used_lw - LW'(1));
      low_a   = AW'(used_lw - nreq);
      // Right rotate walks downward from the top, left rotate walks upward.
      prev_a  = right_ff ? AW'(cur_ff + AW'(1)) : AW'(cur_ff - AW'(1));
      next_a  = right_ff ? AW'(cur_ff - AW'(1)) : AW'(cur_ff + AW'(1));
   end

   always_comb begin
      state_in    = state_ff;
      used_in     = used_ff;
      data_in     = data_ff;
      status_in   = status_ff;
      dup_in      = dup_ff;
      right_in    = right_ff;
      first_in    = first_ff;
      cur_in      = cur_ff;
      left_in     = left_ff;
      keep_in     = keep_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = cur_ff;
      ram_wr_data = keep_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = cur_ff;
      rsp_load    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               data_in   = '0;
               status_in = bsr_pkg::ST_OK;
               state_in  = S_DONE;
               case (req.cmd)
                  bsr_pkg::CMD_PUSH: begin
                     if (full) begin
                        status_in = bsr_pkg::ST_OVERFLOW;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = AW'(used_ff);
                        ram_wr_data = WIDTH'(64'(req.value));
                        used_in     = UW'(used_ff + UW'(1));
                     end
                  end
                  bsr_pkg::CMD_POP, bsr_pkg::CMD_PEEK: begin
                     if (empty) begin
                        status_in = bsr_pkg::ST_EMPTY;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = top_a;
                        dup_in      = 1'b0;
                        state_in    = S_READ;
                        if (req.cmd == bsr_pkg::CMD_POP) begin
                           used_in = UW'(used_ff - UW'(1));
                        end
                     end
                  end
                  bsr_pkg::CMD_DUP: begin
                     if (empty) begin
                        status_in = bsr_pkg::ST_EMPTY;
                     end else if (full) begin
                        status_in = bsr_pkg::ST_OVERFLOW;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = top_a;
                        dup_in      = 1'b1;
                        state_in    = S_READ;
                     end
                  end
                  bsr_pkg::CMD_ROTR, bsr_pkg::CMD_ROTL, bsr_pkg::CMD_SWAP: begin
                     if (bad_n) begin
                        status_in = bsr_pkg::ST_BADN;
                     end else if (n5 != 5'd1) begin
                        right_in    = (req.cmd != bsr_pkg::CMD_ROTL);
                        cur_in      = (req.cmd != bsr_pkg::CMD_ROTL) ? top_a : low_a;
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = cur_in;
                        left_in     = AW'(nreq - LW'(1));
                        first_in    = 1'b1;
                        state_in    = S_ROT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            if (dup_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = AW'(used_ff);
               ram_wr_data = ram_rd_data;
               used_in     = UW'(used_ff + UW'(1));
            end else begin
               data_in = 32'(64'(ram_rd_data));
            end
            state_in = S_DONE;
         end
         S_ROT: begin
            // The first word read is held aside; every later word moves one
            // place toward the start of the walk.
            first_in = 1'b0;
            if (first_ff) begin
               keep_in = ram_rd_data;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = prev_a;
               ram_wr_data = ram_rd_data;
            end
            if (left_ff != '0) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = next_a;
               cur_in      = next_a;
               left_in     = AW'(left_ff - AW'(1));
            end else begin
               state_in = S_ROTEND;
            end
         end
         S_ROTEND: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cur_ff;
            ram_wr_data = keep_ff;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff   <= data_in;
      status_ff <= status_in;
      dup_ff    <= dup_in;
      right_ff  <= right_in;
      first_ff  <= first_in;
      cur_ff    <= cur_in;
      left_ff   <= left_in;
      keep_ff   <= keep_in;
   end

   assign idle = (state_ff == S_IDLE);

   always_comb begin
      rsp.data   = data_ff;
      rsp.status = status_ff;
      rsp.fill   = 5'(used_ff);
   end

endmodule

// ----- hw/rtl/bounded_stack_with_rotate.sv -----
// Top level of the bounded stack with rotate: channels, limit register and response register.
//
// Usage: each request transaction carries one command (push, pop, peek, duplicate,
// rotate right, rotate left, swap) and produces exactly one response transaction
// with the word read, a status code and the fill count after the command.
// The csr channel writes the depth limit; it is always ready and should only be
// written while no command is in flight. Values above DEPTH act as DEPTH.
// Flow: a command is taken only while the sequencer is idle. Push, overflow,
// empty and bad-count cases go straight from idle to the done state; pop, peek and
// duplicate pass through a read state because the stack word comes from the memory's
// registered read port; a rotate over two or more entries reads them one at a time,
// holds the first aside, writes each later one a place back, then writes the held word.
// The finished response is loaded into the output register once that register is free.
// Reset (synchronous, active high) empties the stack and sets the limit to 16;
// the memory contents are not cleared. When the receiver stalls, the finished
// response waits in the output register while the next command is processed;
// that command's result then waits inside the sequencer until the register frees.
module bounded_stack_with_rotate #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // value [31:0], count [36:32], zero pad [39:37]
   input  logic [2:0]  req_tuser,   // cmd [2:0]
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // data [31:0], status [33:32], fill [38:34], zero pad [39]
   // Limit register write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data     // max_depth [4:0]
);

   localparam int AW = $clog2(DEPTH);

   logic [4:0]       max_depth_ff;
   logic             rsp_tvalid_ff;
   bsr_pkg::rsp_type rsp_ff;

   bsr_pkg::req_type req;
   bsr_pkg::rsp_type rsp;
   logic             idle, start, rsp_free, rsp_load;

   logic             ram_wr_en, ram_rd_en;
   logic [AW-1:0]    ram_wr_addr, ram_rd_addr;
   logic [WIDTH-1:0] ram_wr_data, ram_rd_data;

   always_comb begin
      req.cmd   = req_tuser;
      req.value = req_tdata[31:0];
      req.count = req_tdata[36:32];
   end

   assign req_tready = idle;
   assign start      = req_tvalid && idle;
   assign csr_ready  = 1'b1;

   // The output register is free when empty or being drained this cycle.
   assign rsp_free = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_depth_ff  <= 5'd16;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            max_depth_ff <= csr_data;
         end
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.fill, rsp_ff.status, rsp_ff.data};

   bsr_seq #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .max_depth   (max_depth_ff),
      .start       (start),
      .req         (req),
      .idle        (idle),
      .rsp_free    (rsp_free),
      .rsp_load    (rsp_load),
      .rsp         (rsp),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   bsr_ram #(
      .DATA_W (WIDTH),
      .DEPTH  (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
